FILE: design/animation_phase_accumulator_core_defines.svh
// Assertion macros for the animation phase accumulator
`ifndef ANIMATION_PHASE_ACCUMULATOR_CORE_DEFINES_SVH
`define ANIMATION_PHASE_ACCUMULATOR_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS

`define APA_ASSERT_NEVER(label, expr) \
	label: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) \
		else $error("apa: forbidden condition seen");

`define APA_ASSERT_IMPLIES(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("apa: implication violated");

`else

`define APA_ASSERT_NEVER(label, expr)

`define APA_ASSERT_IMPLIES(label, ante, cons)

`endif

`endif

FILE: design/apa_pkg.sv
// Shared constants, types and register codes of the animation phase accumulator
package apa_pkg;

	localparam int unsigned FRAC_BITS  = 16;
	localparam int unsigned MAX_FRAMES = 256;

	localparam int unsigned FT_W      = 17;
	localparam int unsigned SPEED_W   = 20;
	localparam int unsigned SPAN_W    = 25;
	localparam int unsigned POS_W     = 24;
	localparam int unsigned FRAME_W   = 8;
	localparam int unsigned BLEND_W   = 16;
	localparam int unsigned COMP_W    = 17;
	localparam int unsigned PROD_W    = FT_W + SPEED_W;
	localparam int unsigned STEP_W    = PROD_W - FRAC_BITS;
	localparam int unsigned CFG_IDX_W = 3;
	localparam int unsigned CFG_DAT_W = SPAN_W;

	localparam longint unsigned SPAN_RAW = longint'(MAX_FRAMES) << FRAC_BITS;
	localparam longint unsigned POS_TOP  = longint'(1) << POS_W;
	localparam longint unsigned SPAN_CAP = (SPAN_RAW > POS_TOP) ? POS_TOP : SPAN_RAW;

	localparam logic [SPAN_W-1:0] SPAN_LIM   = SPAN_W'(SPAN_CAP);
	localparam logic [COMP_W-1:0] ONE_FX     = COMP_W'(longint'(1) << FRAC_BITS);
	localparam logic [SPEED_W-1:0] SPEED_RST = SPEED_W'(65536);
	localparam logic [SPAN_W-1:0] SPAN_RST   = SPAN_W'(65536);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PLAY_ENABLE  = 3'd0,
		REG_REVERSE_MODE = 3'd1,
		REG_NO_LOOP      = 3'd2,
		REG_SPEED        = 3'd3,
		REG_SEQ_SPAN     = 3'd4
	} reg_idx_t;

	typedef struct packed {
		logic                play_enable;
		logic                reverse_mode;
		logic                no_loop;
		logic [SPEED_W-1:0]  speed;
		logic [SPAN_W-1:0]   sequence_span;
	} cfg_t;

	typedef struct packed {
		logic              valid;
		logic [STEP_W-1:0] step;
	} step_t;

endpackage

FILE: design/apa_if.sv
// Handshake channel interfaces of the animation phase accumulator
interface apa_tick_if;
	logic                       valid;
	logic                       ready;
	logic [apa_pkg::FT_W-1:0]   frame_time;

	modport source (output valid, output frame_time, input ready);
	modport sink (input valid, input frame_time, output ready);
endinterface

interface apa_result_if;
	logic                         valid;
	logic                         ready;
	logic [apa_pkg::POS_W-1:0]    position;
	logic [apa_pkg::FRAME_W-1:0]  frame_index;
	logic [apa_pkg::BLEND_W-1:0]  blend_fraction;
	logic [apa_pkg::COMP_W-1:0]   blend_complement;
	logic                         finished_flag;
	logic                         looped_flag;
	logic                         start_flag;
	logic                         end_flag;

	modport source (output valid, output position, output frame_index, output blend_fraction,
		output blend_complement, output finished_flag, output looped_flag,
		output start_flag, output end_flag, input ready);
	modport sink (input valid, input position, input frame_index, input blend_fraction,
		input blend_complement, input finished_flag, input looped_flag,
		input start_flag, input end_flag, output ready);
endinterface

interface apa_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [apa_pkg::CFG_IDX_W-1:0]  index;
	logic [apa_pkg::CFG_DAT_W-1:0]  data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

FILE: design/apa_step.sv
// Tick input register and speed scaling stage
module apa_step (
	input  logic                          clk,
	input  logic                          arst_n,
	apa_tick_if.sink                      tick,
	input  logic [apa_pkg::SPEED_W-1:0]   speed,
	input  logic                          take,
	output apa_pkg::step_t                stage
);

	logic                         v_s1;
	logic [apa_pkg::FT_W-1:0]     ft_s1;
	logic                         v_s2;
	logic [apa_pkg::STEP_W-1:0]   step_s2;
	logic                         ready_s1;
	logic                         ready_s2;
	logic [apa_pkg::PROD_W-1:0]   prod;

	assign ready_s2   = !v_s2 || take;
	assign ready_s1   = !v_s1 || ready_s2;
	assign tick.ready = ready_s1;

	assign prod = apa_pkg::PROD_W'(ft_s1) * apa_pkg::PROD_W'(speed);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			if (ready_s1)
				v_s1 <= tick.valid;
			if (ready_s2)
				v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && tick.valid)
			ft_s1 <= tick.frame_time;
		if (ready_s2 && v_s1)
			step_s2 <= prod[apa_pkg::PROD_W-1:apa_pkg::FRAC_BITS];
	end

	assign stage.valid = v_s2;
	assign stage.step  = step_s2;

endmodule

FILE: design/apa_phase.sv
// Position update, sticky flags and result register
module apa_phase (
	input  logic              clk,
	input  logic              arst_n,
	input  apa_pkg::cfg_t     cfg,
	input  apa_pkg::step_t    stage,
	output logic              take,
	apa_result_if.source      result
);

	localparam int unsigned SW = apa_pkg::SPAN_W;

	logic                        out_v_q;
	logic [apa_pkg::POS_W-1:0]   phase_q;
	logic                        finished_q;
	logic                        looped_q;
	logic                        start_q;
	logic                        end_q;

	logic [SW-1:0]               span;
	logic [SW-1:0]               cur;
	logic [SW-1:0]               stp;
	logic [SW-1:0]               fwd;
	logic [SW-1:0]               fwd_wrap;
	logic [SW-1:0]               deficit;
	logic [SW-1:0]               nxt;
	logic                        set_fin;
	logic                        set_loop;
	logic                        set_start;
	logic                        set_end;

	assign take = stage.valid && (!out_v_q || result.ready);

	always_comb begin
		if (cfg.sequence_span == '0)
			span = SW'(1);
		else if (cfg.sequence_span > apa_pkg::SPAN_LIM)
			span = apa_pkg::SPAN_LIM;
		else
			span = cfg.sequence_span;
	end

	assign cur      = SW'(phase_q);
	assign stp      = SW'(stage.step);
	assign fwd      = cur + stp;
	assign fwd_wrap = fwd - span;
	assign deficit  = stp - cur;

	always_comb begin
		nxt       = cur;
		set_fin   = 1'b0;
		set_loop  = 1'b0;
		set_start = 1'b0;
		set_end   = 1'b0;
		if (cfg.reverse_mode) begin
			if (stp > cur) begin
				if (cfg.no_loop) begin
					nxt       = '0;
					set_fin   = 1'b1;
					set_start = 1'b1;
				end else begin
					nxt      = (deficit > span) ? '0 : span - deficit;
					set_loop = 1'b1;
					set_end  = 1'b1;
				end
			end else begin
				nxt = cur - stp;
			end
		end else begin
			if (fwd >= span) begin
				if (cfg.no_loop) begin
					nxt     = span - SW'(1);
					set_fin = 1'b1;
					set_end = 1'b1;
				end else begin
					nxt       = (fwd_wrap >= span) ? span - SW'(1) : fwd_wrap;
					set_loop  = 1'b1;
					set_start = 1'b1;
				end
			end else begin
				nxt = fwd;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q    <= 1'b0;
			phase_q    <= '0;
			finished_q <= 1'b0;
			looped_q   <= 1'b0;
			start_q    <= 1'b0;
			end_q      <= 1'b0;
		end else begin
			if (take) begin
				out_v_q <= 1'b1;
				if (cfg.play_enable) begin
					phase_q    <= apa_pkg::POS_W'(nxt);
					finished_q <= finished_q | set_fin;
					looped_q   <= looped_q | set_loop;
					start_q    <= start_q | set_start;
					end_q      <= end_q | set_end;
				end
			end else if (result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign result.valid            = out_v_q;
	assign result.position         = phase_q;
	assign result.frame_index      = phase_q[apa_pkg::FRAC_BITS +: apa_pkg::FRAME_W];
	assign result.blend_fraction   = apa_pkg::BLEND_W'(phase_q[apa_pkg::FRAC_BITS-1:0]);
	assign result.blend_complement = apa_pkg::ONE_FX
		- apa_pkg::COMP_W'(phase_q[apa_pkg::FRAC_BITS-1:0]);
	assign result.finished_flag    = finished_q;
	assign result.looped_flag      = looped_q;
	assign result.start_flag       = start_q;
	assign result.end_flag         = end_q;

endmodule

FILE: design/animation_phase_accumulator_core.sv
// Top level of the animation phase accumulator
//
//  channel  | dir | payload                                         | transfer
//  ---------+-----+-------------------------------------------------+---------------------
//  tick     | in  | frame_time                                      | valid & ready
//  result   | out | position, frame_index, blend weights, 4 flags   | valid & ready
//  cfg      | in  | index, data                                     | valid & ready
//
// One tick a cycle sustained while result.ready holds. From tick transfer to result valid:
// input register, scaled step register, then position update into the result register.
// The position loop runs from the position register through an add, compares and subtracts.
// arst_n clears the position, sticky flags and valid bits and resets the config registers.
// A stalled result holds; up to three ticks sit in the stages before tick.ready drops.
`include "animation_phase_accumulator_core_defines.svh"

module animation_phase_accumulator_core (
	input  logic          clk,
	input  logic          arst_n,
	apa_tick_if.sink      tick,
	apa_result_if.source  result,
	apa_cfg_if.sink       cfg
);

	apa_pkg::cfg_t   cfg_q;
	apa_pkg::step_t  stage;
	logic            take;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.play_enable   <= 1'b0;
			cfg_q.reverse_mode  <= 1'b0;
			cfg_q.no_loop       <= 1'b0;
			cfg_q.speed         <= apa_pkg::SPEED_RST;
			cfg_q.sequence_span <= apa_pkg::SPAN_RST;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				apa_pkg::REG_PLAY_ENABLE:  cfg_q.play_enable   <= cfg.data[0];
				apa_pkg::REG_REVERSE_MODE: cfg_q.reverse_mode  <= cfg.data[0];
				apa_pkg::REG_NO_LOOP:      cfg_q.no_loop       <= cfg.data[0];
				apa_pkg::REG_SPEED:        cfg_q.speed <= cfg.data[apa_pkg::SPEED_W-1:0];
				apa_pkg::REG_SEQ_SPAN:     cfg_q.sequence_span <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	apa_step u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.tick   (tick),
		.speed  (cfg_q.speed),
		.take   (take),
		.stage  (stage)
	);

	apa_phase u_phase (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg_q),
		.stage  (stage),
		.take   (take),
		.result (result)
	);

	`APA_ASSERT_NEVER(a_sticky_hold_a, $fell(result.finished_flag) || $fell(result.looped_flag))
	`APA_ASSERT_NEVER(a_sticky_hold_b, $fell(result.start_flag) || $fell(result.end_flag))
	`APA_ASSERT_IMPLIES(a_loop_mode, $rose(result.looped_flag), !$past(cfg_q.no_loop))
	`APA_ASSERT_IMPLIES(a_finish_mode, $rose(result.finished_flag), $past(cfg_q.no_loop))

endmodule
